[rtl/assert_macros.svh]
// Assertion macros of the bilinear image sampler, used by its top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication or plain property, checked on every rising edge outside reset.
`define BIS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition that must never hold outside reset.
`define BIS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define BIS_ASSERT(lbl, clk, rst_n, prop)
`define BIS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[rtl/bis_pkg.sv]
// Shared constants and types of the bilinear image sampler.
package bis_pkg;

    localparam int COORD_W   = 17;
    localparam int PIX_W     = 8;
    localparam int PIX_IDX_W = 8;
    localparam int CFG_W     = 9;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 8;

    localparam logic [CFG_W-1:0] RESET_DIM = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [0:0] REQ_LOAD   = 1'b0;
    localparam logic [0:0] REQ_SAMPLE = 1'b1;

    // Control word for the shared multiply-accumulate unit.
    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
        logic acc_sel;
    } mac_ctrl_t;

endpackage

[rtl/bis_ram.sv]
// Generic single-port RAM with a registered read.
module bis_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bis_coord.sv]
// Coordinate clamp: integer part, edge-clamped neighbour and fraction of one axis.
module bis_coord #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic signed [bis_pkg::COORD_W-1:0] coord,
    input  logic [bis_pkg::CFG_W-1:0]          dim,
    output logic [bis_pkg::CFG_W-1:0]          base,
    output logic [bis_pkg::CFG_W-1:0]          next,
    output logic [FRAC_BITS-1:0]               frac
);

    import bis_pkg::*;

    localparam int HI_W  = CFG_W + FRAC_BITS;
    localparam int CMP_W = (HI_W > COORD_W - 1) ? HI_W : COORD_W - 1;

    logic [CFG_W-1:0] dim_use;
    logic [CFG_W-1:0] dim_m1;
    logic [CMP_W-1:0] hi;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] clamped;
    logic [CFG_W:0]   base_p1;

    always_comb
    begin
        // The dimension in use is kept between two and the store size.
        if (dim < CFG_W'(2))
        begin
            dim_use = CFG_W'(2);
        end
        else if (32'(dim) > 32'(MAX_DIM))
        begin
            dim_use = CFG_W'(MAX_DIM);
        end
        else
        begin
            dim_use = dim;
        end
        dim_m1 = dim_use - CFG_W'(1);
        hi     = CMP_W'({dim_m1, {FRAC_BITS{1'b0}}});
        pos    = CMP_W'(coord[COORD_W-2:0]);

        if (coord[COORD_W-1])
        begin
            clamped = '0;
        end
        else if (pos > hi)
        begin
            clamped = hi;
        end
        else
        begin
            clamped = pos;
        end

        base    = clamped[FRAC_BITS +: CFG_W];
        frac    = clamped[FRAC_BITS-1:0];
        base_p1 = {1'b0, base} + (CFG_W + 1)'(1);
        if (base_p1 < {1'b0, dim_use})
        begin
            next = base_p1[CFG_W-1:0];
        end
        else
        begin
            next = dim_m1;
        end
    end

endmodule

[rtl/bis_mac.sv]
// Shared multiplier with registered product and two accumulators.
module bis_mac #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                   clk,
    input  bis_pkg::mac_ctrl_t                     ctrl,
    input  logic [bis_pkg::PIX_W+FRAC_BITS-1:0]    mul_a,
    input  logic [FRAC_BITS:0]                     mul_b,
    output logic [bis_pkg::PIX_W+2*FRAC_BITS-1:0]  acc0,
    output logic [bis_pkg::PIX_W+2*FRAC_BITS-1:0]  acc1
);

    import bis_pkg::*;

    localparam int A_W   = PIX_W + FRAC_BITS;
    localparam int B_W   = FRAC_BITS + 1;
    localparam int ACC_W = PIX_W + 2 * FRAC_BITS;

    logic [A_W+B_W-1:0] prod_full;
    logic [ACC_W-1:0]   prod_reg;
    logic [ACC_W-1:0]   acc0_reg;
    logic [ACC_W-1:0]   acc1_reg;
    logic [ACC_W-1:0]   acc_sel_val;
    logic [ACC_W-1:0]   acc_next;

    // Every product of the blend stays at or below 255 * 2^(2*FRAC_BITS).
    assign prod_full   = (A_W + B_W)'(mul_a) * (A_W + B_W)'(mul_b);
    assign acc_sel_val = ctrl.acc_sel ? acc1_reg : acc0_reg;
    assign acc_next    = ctrl.acc_load ? prod_reg : acc_sel_val + prod_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_full[ACC_W-1:0];
        end
        if (ctrl.acc_load || ctrl.acc_add)
        begin
            if (ctrl.acc_sel)
            begin
                acc1_reg <= acc_next;
            end
            else
            begin
                acc0_reg <= acc_next;
            end
        end
    end

    assign acc0 = acc0_reg;
    assign acc1 = acc1_reg;

endmodule

[rtl/bilinear_image_sampler.sv]
// Top level of the bilinear image sampler: image store, sequencer and output register.
//
// The block keeps a MAX_WIDTH x MAX_HEIGHT store of 8-bit gray pixels in a
// single-port RAM and serves two kinds of input word. A load word
// (req_type 0) writes one pixel in the cycle it is accepted; a load
// outside the store is dropped and gives no result. A sample word
// (req_type 1) clamps sample_x and sample_y to the image in use (set by
// the width and height configuration registers), clamps the right and lower
// neighbours to the edge, reads the four pixels one after another through
// the single RAM port and blends them with one shared multiplier: first
// horizontally, then vertically, truncating the final sum by FRAC_BITS.
// A sample occupies the block after acceptance until its result is
// registered: four RAM reads overlap with the first products, and the six
// products on the one multiplier set the length. in_stall is high throughout.
// The result word goes into an output register, so the block takes the next
// input word while a result still waits; a sample only holds in its last
// step if the previous result has not been taken. Configuration writes are
// meant for idle periods. The store has no reset: a pixel must be loaded
// before a sample reads it.
`include "assert_macros.svh"

module bilinear_image_sampler #(
    parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = bis_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_write,
    input  logic [bis_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bis_pkg::CFG_W-1:0]          cfg_data,
    // Input channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic [bis_pkg::PIX_IDX_W-1:0]      pixel_col,
    input  logic [bis_pkg::PIX_IDX_W-1:0]      pixel_row,
    input  logic [bis_pkg::PIX_W-1:0]          pixel_value,
    input  logic signed [bis_pkg::COORD_W-1:0] sample_x,
    input  logic signed [bis_pkg::COORD_W-1:0] sample_y,
    // Output channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [bis_pkg::OUT_W-1:0]          sample_value
);

    import bis_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int A_W    = PIX_W + FRAC_BITS;
    localparam int B_W    = FRAC_BITS + 1;
    localparam int ACC_W  = PIX_W + 2 * FRAC_BITS;
    localparam int VAL_W  = ACC_W - FRAC_BITS;

    localparam logic [B_W-1:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};

    // Sequencer states.
    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_RUN  = 1'b1;

    // Steps of a sample. The first four steps address the four pixels; the
    // RAM read is registered, so each product is formed in the step after its address.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_A00  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_A10  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_A01  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_A11  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_M11  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ADDB = 4'd5;
    localparam logic [STEP_W-1:0] STEP_MTOP = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MBOT = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SUM  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_DONE = 4'd9;

    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;
    logic [0:0]           state_reg;
    logic [0:0]           state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_value_reg;

    logic [CFG_W-1:0]     x0_reg;
    logic [CFG_W-1:0]     x1_reg;
    logic [CFG_W-1:0]     y0_reg;
    logic [CFG_W-1:0]     y1_reg;
    logic [FRAC_BITS-1:0] dx_reg;
    logic [FRAC_BITS-1:0] dy_reg;

    logic [CFG_W-1:0]     x0_c;
    logic [CFG_W-1:0]     x1_c;
    logic [CFG_W-1:0]     y0_c;
    logic [CFG_W-1:0]     y1_c;
    logic [FRAC_BITS-1:0] dx_c;
    logic [FRAC_BITS-1:0] dy_c;

    logic                 in_accept;
    logic                 out_take;
    logic                 col_ok;
    logic                 row_ok;
    logic                 ram_we;
    logic [CFG_W-1:0]     col_sel;
    logic [CFG_W-1:0]     row_sel;
    logic [ADDR_W-1:0]    ram_addr;
    logic [PIX_W-1:0]     ram_rdata;

    logic [B_W-1:0]       wx0;
    logic [B_W-1:0]       wx1;
    logic [B_W-1:0]       wy0;
    logic [B_W-1:0]       wy1;
    mac_ctrl_t            mac_ctrl;
    logic [A_W-1:0]       mul_a;
    logic [B_W-1:0]       mul_b;
    logic [ACC_W-1:0]     acc0;
    logic [ACC_W-1:0]     acc1;
    logic [VAL_W-1:0]     blend_val;
    logic [OUT_W-1:0]     blend_sat;
    logic                 done_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign done_free = !out_valid_reg || !out_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_DIM;
            height_reg <= RESET_DIM;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // Coordinate clamping works straight off the input word, so the
    // corner indices and fractions are registered at acceptance.
    bis_coord #(
        .MAX_DIM   (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_coord_x (
        .coord (sample_x),
        .dim   (width_reg),
        .base  (x0_c),
        .next  (x1_c),
        .frac  (dx_c)
    );

    bis_coord #(
        .MAX_DIM   (MAX_HEIGHT),
        .FRAC_BITS (FRAC_BITS)
    ) u_coord_y (
        .coord (sample_y),
        .dim   (height_reg),
        .base  (y0_c),
        .next  (y1_c),
        .frac  (dy_c)
    );

    always_ff @(posedge clk)
    begin
        if (in_accept && (req_type == REQ_SAMPLE))
        begin
            x0_reg <= x0_c;
            x1_reg <= x1_c;
            y0_reg <= y0_c;
            y1_reg <= y1_c;
            dx_reg <= dx_c;
            dy_reg <= dy_c;
        end
    end

    // Loads outside the store are dropped; loads outside the image in use
    // but inside the store are still written.
    assign col_ok = (32'(pixel_col) < 32'(MAX_WIDTH));
    assign row_ok = (32'(pixel_row) < 32'(MAX_HEIGHT));
    assign ram_we = in_accept && (req_type == REQ_LOAD) && col_ok && row_ok;

    // Pixel address selection: the load position while idle, otherwise the
    // corner that the current step reads.
    always_comb
    begin
        col_sel = x0_reg;
        row_sel = y0_reg;
        if (state_reg == ST_IDLE)
        begin
            col_sel = {1'b0, pixel_col};
            row_sel = {1'b0, pixel_row};
        end
        else
        begin
            unique case (step_reg)
                STEP_A10:
                begin
                    col_sel = x1_reg;
                end
                STEP_A01:
                begin
                    row_sel = y1_reg;
                end
                STEP_A11:
                begin
                    col_sel = x1_reg;
                    row_sel = y1_reg;
                end
                default:
                begin
                    col_sel = x0_reg;
                    row_sel = y0_reg;
                end
            endcase
        end
    end

    assign ram_addr = ADDR_W'(row_sel) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_sel);

    bis_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pixel_value),
        .rdata (ram_rdata)
    );

    // Blend weights.
    assign wx1 = {1'b0, dx_reg};
    assign wy1 = {1'b0, dy_reg};
    assign wx0 = ONE_W - wx1;
    assign wy0 = ONE_W - wy1;

    // Step decoder for the shared multiply-accumulate unit. Accumulator 0
    // holds the top row and later the final sum; accumulator 1 the bottom.
    always_comb
    begin
        mac_ctrl = '0;
        mul_a    = A_W'(ram_rdata);
        mul_b    = wx0;
        if (state_reg == ST_RUN)
        begin
            unique case (step_reg)
                STEP_A10:
                begin
                    mac_ctrl.mul_en = 1'b1;
                end
                STEP_A01:
                begin
                    mac_ctrl.mul_en   = 1'b1;
                    mac_ctrl.acc_load = 1'b1;
                    mul_b             = wx1;
                end
                STEP_A11:
                begin
                    mac_ctrl.mul_en  = 1'b1;
                    mac_ctrl.acc_add = 1'b1;
                end
                STEP_M11:
                begin
                    mac_ctrl.mul_en   = 1'b1;
                    mac_ctrl.acc_load = 1'b1;
                    mac_ctrl.acc_sel  = 1'b1;
                    mul_b             = wx1;
                end
                STEP_ADDB:
                begin
                    mac_ctrl.acc_add = 1'b1;
                    mac_ctrl.acc_sel = 1'b1;
                end
                STEP_MTOP:
                begin
                    mac_ctrl.mul_en = 1'b1;
                    mul_a           = acc0[A_W-1:0];
                    mul_b           = wy0;
                end
                STEP_MBOT:
                begin
                    mac_ctrl.mul_en   = 1'b1;
                    mac_ctrl.acc_load = 1'b1;
                    mul_a             = acc1[A_W-1:0];
                    mul_b             = wy1;
                end
                STEP_SUM:
                begin
                    mac_ctrl.acc_add = 1'b1;
                end
                default:
                begin
                    mac_ctrl = '0;
                end
            endcase
        end
    end

    bis_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .ctrl  (mac_ctrl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .acc0  (acc0),
        .acc1  (acc1)
    );

    // Final truncation; saturation can only bite when FRAC_BITS exceeds 8.
    assign blend_val = acc0[ACC_W-1:FRAC_BITS];
    always_comb
    begin
        if (32'(blend_val) > 32'({OUT_W{1'b1}}))
        begin
            blend_sat = {OUT_W{1'b1}};
        end
        else
        begin
            blend_sat = OUT_W'(blend_val);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (req_type == REQ_SAMPLE))
                begin
                    state_next = ST_RUN;
                    step_next  = STEP_A00;
                end
            end
            ST_RUN:
            begin
                if (step_reg == STEP_DONE)
                begin
                    if (done_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_A00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_RUN) && (step_reg == STEP_DONE) && done_free)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_RUN) && (step_reg == STEP_DONE) && done_free)
        begin
            out_value_reg <= blend_sat;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = out_value_reg;

    // The store is never written while a sample is reading it.
    `BIS_ASSERT_NEVER(a_no_write_in_run, clk, rst_n, (state_reg == ST_RUN) && ram_we)
    // The step counter stays within the sample schedule.
    `BIS_ASSERT(a_step_bound, clk, rst_n, (state_reg == ST_RUN) |-> (step_reg <= STEP_DONE))
    // A result appears only at the end of a sample.
    `BIS_ASSERT(a_result_source, clk, rst_n,
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RUN) && ($past(step_reg) == STEP_DONE))

endmodule
